// ===== design/atwa_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package atwa_pkg;

  localparam int CNT_W = 16;
  localparam int EK_W  = 48;
  localparam int EV_W  = 3;
  localparam int KIND_W = 2;
  localparam int CIDX_W = 2;

  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  localparam logic [KIND_W-1:0] KIND_OBSERVE = 2'd0;
  localparam logic [KIND_W-1:0] KIND_MARK    = 2'd1;
  localparam logic [KIND_W-1:0] KIND_SCAN    = 2'd2;

  localparam logic [EV_W-1:0] EV_KNOWN       = 3'd0;
  localparam logic [EV_W-1:0] EV_NEW_FLAGGED = 3'd1;
  localparam logic [EV_W-1:0] EV_NEW_WARMUP  = 3'd2;
  localparam logic [EV_W-1:0] EV_VANISHED    = 3'd3;
  localparam logic [EV_W-1:0] EV_DONE        = 3'd4;

  localparam logic [CIDX_W-1:0] REG_WARMUP   = 2'd0;
  localparam logic [CIDX_W-1:0] REG_VANISH   = 2'd1;
  localparam logic [CIDX_W-1:0] REG_BASELINE = 2'd2;

  localparam logic [CNT_W-1:0] WARMUP_RST   = 16'd10;
  localparam logic [CNT_W-1:0] VANISH_RST   = 16'd10;
  localparam logic [CNT_W-1:0] BASELINE_RST = 16'd3;

  typedef struct packed {
    logic [CNT_W-1:0] warmup_scans;
    logic [CNT_W-1:0] vanish_misses;
    logic [CNT_W-1:0] baseline_observations;
  } cfg_t;

  typedef struct packed {
    logic             match;
    logic             vanish;
    logic [CNT_W-1:0] obs_next;
    logic [CNT_W-1:0] miss_next;
  } unit_res_t;

endpackage

`default_nettype wire

// ===== design/atwa_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module atwa_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 80,
  parameter int AW    = 6
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // write-first on a same-address read
  always_ff @(posedge clk) begin
    if (we && (waddr == raddr)) begin
      rdata <= wdata;
    end else begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== design/atwa_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none

module atwa_unit #(
  parameter int KEY_BITS = 48
) (
  input  wire logic [KEY_BITS+2*atwa_pkg::CNT_W-1:0] word,
  input  wire logic [KEY_BITS-1:0]                   key,
  input  wire atwa_pkg::cfg_t                        cfg,
  output atwa_pkg::unit_res_t                        res
);
  import atwa_pkg::*;

  localparam int W = KEY_BITS + 2 * CNT_W;

  logic [KEY_BITS-1:0] ekey;
  logic [CNT_W-1:0]    obs;
  logic [CNT_W-1:0]    miss;

  assign ekey = word[W-1 -: KEY_BITS];
  assign obs  = word[2*CNT_W-1:CNT_W];
  assign miss = word[CNT_W-1:0];

  always_comb begin
    res.match     = (ekey == key);
    res.obs_next  = (obs == CNT_MAX) ? obs : obs + CNT_W'(1);
    res.miss_next = (miss == CNT_MAX) ? miss : miss + CNT_W'(1);
    res.vanish    = (res.miss_next > cfg.vanish_misses) &&
                    (obs >= cfg.baseline_observations);
  end

endmodule

`default_nettype wire

// ===== design/atwa_seq.sv =====
`timescale 1ns / 1ps
`default_nettype none

module atwa_seq #(
  parameter int TABLE_DEPTH = 64,
  parameter int KEY_BITS    = 48,
  parameter int IW          = 6,
  parameter int CW          = 7
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  start,
  input  wire logic [atwa_pkg::KIND_W-1:0]           kind,
  input  wire logic [KEY_BITS-1:0]                   key,
  output logic                                       busy,
  input  wire atwa_pkg::cfg_t                        cfg,
  input  wire atwa_pkg::unit_res_t                   ures,
  output logic [KEY_BITS-1:0]                        key_cur,
  output logic                                       ram_we,
  output logic [IW-1:0]                              ram_waddr,
  output logic [KEY_BITS+2*atwa_pkg::CNT_W-1:0]      ram_wdata,
  output logic [IW-1:0]                              ram_raddr,
  input  wire logic [KEY_BITS+2*atwa_pkg::CNT_W-1:0] ram_rdata,
  output logic                                       result_strobe,
  output logic [atwa_pkg::EV_W-1:0]                  event_res,
  output logic [atwa_pkg::EK_W-1:0]                  event_key,
  output logic                                       was_inserted,
  output logic [CW-1:0]                              entries_held,
  output logic                                       last_result
);
  import atwa_pkg::*;

  localparam int W = KEY_BITS + 2 * CNT_W;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SEARCH = 3'd1;
  localparam logic [2:0] S_MISS   = 3'd2;
  localparam logic [2:0] S_AGE    = 3'd3;
  localparam logic [2:0] S_MOVE   = 3'd4;
  localparam logic [2:0] S_END    = 3'd5;

  logic [2:0]             state;
  logic [KIND_W-1:0]      kind_q;
  logic [KEY_BITS-1:0]    key_q;
  logic [IW-1:0]          idx;
  logic [CW-1:0]          total;
  logic [CNT_W-1:0]       scans;
  logic [TABLE_DEPTH-1:0] seen;
  logic                   pend_valid;
  logic [EK_W-1:0]        pend_key;
  logic [CW-1:0]          pend_held;

  logic [KEY_BITS-1:0]    rkey;
  logic [CNT_W-1:0]       robs;
  logic                   last_i;
  logic                   full;
  logic [IW-1:0]          lidx;
  logic [IW-1:0]          idx_inc;

  assign rkey    = ram_rdata[W-1 -: KEY_BITS];
  assign robs    = ram_rdata[2*CNT_W-1:CNT_W];
  assign last_i  = ((CW'(idx) + CW'(1)) == total);
  assign full    = (total == CW'(TABLE_DEPTH));
  assign lidx    = IW'(total - CW'(1));
  assign idx_inc = idx + IW'(1);
  assign busy    = (state != S_IDLE);
  assign key_cur = key_q;

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = idx;
    ram_wdata = ram_rdata;
    ram_raddr = '0;
    case (state)
      S_SEARCH: begin
        ram_raddr = idx_inc;
        if (kind_q == KIND_OBSERVE && ures.match) begin
          ram_we    = 1'b1;
          ram_wdata = {rkey, ures.obs_next, CNT_W'(0)};
        end
      end
      S_MISS: begin
        if (kind_q == KIND_OBSERVE && !full) begin
          ram_we    = 1'b1;
          ram_waddr = IW'(total);
          ram_wdata = {key_q, CNT_W'(1), CNT_W'(0)};
        end
      end
      S_AGE: begin
        if (!seen[idx] && ures.vanish && !last_i) begin
          ram_raddr = lidx;
        end else begin
          ram_raddr = idx_inc;
        end
        if (!seen[idx] && !ures.vanish) begin
          ram_we    = 1'b1;
          ram_wdata = {rkey, robs, ures.miss_next};
        end
      end
      S_MOVE: begin
        ram_we    = 1'b1;
        ram_raddr = idx;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      idx           <= '0;
      total         <= '0;
      scans         <= '0;
      seen          <= '0;
      pend_valid    <= 1'b0;
      result_strobe <= 1'b0;
    end else begin
      result_strobe <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            kind_q <= kind;
            key_q  <= key;
            idx    <= '0;
            case (kind)
              KIND_OBSERVE, KIND_MARK: begin
                state <= (total == '0) ? S_MISS : S_SEARCH;
              end
              KIND_SCAN: begin
                if (scans != CNT_MAX) begin
                  scans <= scans + CNT_W'(1);
                end
                state <= (total == '0) ? S_END : S_AGE;
              end
              default: begin
                result_strobe <= 1'b1;
                event_res     <= EV_DONE;
                event_key     <= '0;
                was_inserted  <= 1'b0;
                entries_held  <= total;
                last_result   <= 1'b1;
              end
            endcase
          end
        end
        S_SEARCH: begin
          if (ures.match) begin
            result_strobe <= 1'b1;
            was_inserted  <= 1'b0;
            entries_held  <= total;
            last_result   <= 1'b1;
            if (kind_q == KIND_OBSERVE) begin
              event_res <= EV_KNOWN;
              event_key <= EK_W'(key_q);
            end else begin
              seen[idx] <= 1'b1;
              event_res <= EV_DONE;
              event_key <= '0;
            end
            state <= S_IDLE;
          end else if (last_i) begin
            state <= S_MISS;
          end else begin
            idx <= idx_inc;
          end
        end
        S_MISS: begin
          result_strobe <= 1'b1;
          last_result   <= 1'b1;
          if (kind_q == KIND_OBSERVE) begin
            event_res    <= (scans > cfg.warmup_scans) ? EV_NEW_FLAGGED : EV_NEW_WARMUP;
            event_key    <= EK_W'(key_q);
            was_inserted <= !full;
            if (full) begin
              entries_held <= total;
            end else begin
              entries_held       <= total + CW'(1);
              total              <= total + CW'(1);
              seen[IW'(total)]   <= 1'b0;
            end
          end else begin
            event_res    <= EV_DONE;
            event_key    <= '0;
            was_inserted <= 1'b0;
            entries_held <= total;
          end
          state <= S_IDLE;
        end
        S_AGE: begin
          if (seen[idx] || !ures.vanish) begin
            if (last_i) begin
              state <= S_END;
            end else begin
              idx <= idx_inc;
            end
          end else begin
            // hold back each removal until we know whether it is the final beat
            if (pend_valid) begin
              result_strobe <= 1'b1;
              event_res     <= EV_VANISHED;
              event_key     <= pend_key;
              was_inserted  <= 1'b0;
              entries_held  <= pend_held;
              last_result   <= 1'b0;
            end
            pend_valid <= 1'b1;
            pend_key   <= EK_W'(rkey);
            pend_held  <= total - CW'(1);
            if (last_i) begin
              total     <= total - CW'(1);
              seen[idx] <= 1'b0;
              state     <= S_END;
            end else begin
              state <= S_MOVE;
            end
          end
        end
        S_MOVE: begin
          // last entry fills the freed slot and is examined next
          seen[idx]  <= seen[lidx];
          seen[lidx] <= 1'b0;
          total      <= total - CW'(1);
          state      <= S_AGE;
        end
        S_END: begin
          seen          <= '0;
          pend_valid    <= 1'b0;
          result_strobe <= 1'b1;
          was_inserted  <= 1'b0;
          last_result   <= 1'b1;
          if (pend_valid) begin
            event_res    <= EV_VANISHED;
            event_key    <= pend_key;
            entries_held <= pend_held;
          end else begin
            event_res    <= EV_DONE;
            event_key    <= '0;
            entries_held <= total;
          end
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== design/address_table_with_aging_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Learning table of up to TABLE_DEPTH keys with observation and miss counts.
// An item is taken when start is high and busy is low; for observe, mark and
// scan, busy then stays high until the item's last result has been issued,
// while any other kind gives its single result and busy stays low. Results
// appear on the result ports for a single cycle with result_strobe high and
// must be taken then, since there is no way to hold them off; last_result
// marks the final beat of an item. Observe and mark walk the table one entry
// per cycle through the single read port of the entry memory; a hit ends the
// walk early. A scan end ages one entry per cycle, pausing at each removal
// that leaves a gap to move the last entry into it. Configuration writes are
// always accepted and must only be made while busy is low and no result is
// pending.
module address_table_with_aging_unit #(
  parameter int TABLE_DEPTH = 64,
  parameter int KEY_BITS    = 48
) (
  input  wire logic                                    clk,
  input  wire logic                                    rst,
  input  wire logic                                    start,
  output logic                                         busy,
  input  wire logic [atwa_pkg::KIND_W-1:0]             kind,
  input  wire logic [KEY_BITS-1:0]                     key,
  input  wire logic                                    cfg_valid,
  output logic                                         cfg_ready,
  input  wire logic [atwa_pkg::CIDX_W-1:0]             cfg_index,
  input  wire logic [atwa_pkg::CNT_W-1:0]              cfg_data,
  output logic                                         result_strobe,
  output logic [atwa_pkg::EV_W-1:0]                    event_res,
  output logic [atwa_pkg::EK_W-1:0]                    event_key,
  output logic                                         was_inserted,
  output logic [$clog2(TABLE_DEPTH+1)-1:0]             entries_held,
  output logic                                         last_result
);
  import atwa_pkg::*;

  localparam int IW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int W  = KEY_BITS + 2 * CNT_W;

  cfg_t                cfg;
  unit_res_t           ures;
  logic [KEY_BITS-1:0] key_cur;
  logic                ram_we;
  logic [IW-1:0]       ram_waddr;
  logic [W-1:0]        ram_wdata;
  logic [IW-1:0]       ram_raddr;
  logic [W-1:0]        ram_rdata;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.warmup_scans          <= WARMUP_RST;
      cfg.vanish_misses         <= VANISH_RST;
      cfg.baseline_observations <= BASELINE_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_WARMUP:   cfg.warmup_scans          <= cfg_data;
        REG_VANISH:   cfg.vanish_misses         <= cfg_data;
        REG_BASELINE: cfg.baseline_observations <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  atwa_ram #(
    .DEPTH (TABLE_DEPTH),
    .WIDTH (W),
    .AW    (IW)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  atwa_unit #(
    .KEY_BITS (KEY_BITS)
  ) u_unit (
    .word (ram_rdata),
    .key  (key_cur),
    .cfg  (cfg),
    .res  (ures)
  );

  atwa_seq #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .KEY_BITS    (KEY_BITS),
    .IW          (IW),
    .CW          (CW)
  ) u_seq (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .kind          (kind),
    .key           (key),
    .busy          (busy),
    .cfg           (cfg),
    .ures          (ures),
    .key_cur       (key_cur),
    .ram_we        (ram_we),
    .ram_waddr     (ram_waddr),
    .ram_wdata     (ram_wdata),
    .ram_raddr     (ram_raddr),
    .ram_rdata     (ram_rdata),
    .result_strobe (result_strobe),
    .event_res     (event_res),
    .event_key     (event_key),
    .was_inserted  (was_inserted),
    .entries_held  (entries_held),
    .last_result   (last_result)
  );

  a_fall_last: assert property (@(posedge clk) disable iff (rst)
    $fell(busy) |-> (result_strobe && last_result))
    else $error("busy dropped without a final result beat");

  a_idle_last: assert property (@(posedge clk) disable iff (rst)
    (result_strobe && !busy) |-> last_result)
    else $error("non-final result beat while idle");

  a_mid_vanish: assert property (@(posedge clk) disable iff (rst)
    (result_strobe && !last_result) |-> (event_res == EV_VANISHED))
    else $error("only removals may precede the final beat");

  a_held_range: assert property (@(posedge clk) disable iff (rst)
    result_strobe |-> (entries_held <= CW'(TABLE_DEPTH)))
    else $error("occupancy beyond table depth");

endmodule

`default_nettype wire

// ===== bench/address_table_with_aging_unit_test.sv =====
`timescale 1ns / 1ps

module address_table_with_aging_unit_test;
  import atwa_pkg::*;

  localparam int DEPTH         = 64;
  localparam int KEY_W         = EK_W;
  localparam int HELD_W        = $clog2(DEPTH + 1);
  localparam int IDLE_LIMIT    = 5000;
  localparam int SETTLE_CYCLES = 150;

  localparam logic [KIND_W-1:0] KIND_SPARE = 2'd3;
  localparam logic [CIDX_W-1:0] REG_SPARE  = 2'd3;

  typedef struct packed {
    logic [EV_W-1:0]   res;
    logic [KEY_W-1:0]  ekey;
    logic              inserted;
    logic [HELD_W-1:0] held;
    logic              final_beat;
  } table_event_t;

  class address_table_shadow;
    logic [KEY_W-1:0] keys [DEPTH];
    logic [CNT_W-1:0] obs [DEPTH];
    logic [CNT_W-1:0] miss [DEPTH];
    bit               seen [DEPTH];
    int               total;
    logic [CNT_W-1:0] scans;
    cfg_t             cfg;
    table_event_t     pending [$];
    int               errors;

    function new();
      total = 0;
      scans = '0;
      errors = 0;
      cfg.warmup_scans = WARMUP_RST;
      cfg.vanish_misses = VANISH_RST;
      cfg.baseline_observations = BASELINE_RST;
      foreach (seen[j]) seen[j] = 1'b0;
    endfunction

    function void write_register(logic [CIDX_W-1:0] idx, logic [CNT_W-1:0] val);
      case (idx)
        REG_WARMUP:   cfg.warmup_scans = val;
        REG_VANISH:   cfg.vanish_misses = val;
        REG_BASELINE: cfg.baseline_observations = val;
        default: ;
      endcase
    endfunction

    function int outstanding();
      return pending.size();
    endfunction

    function int held();
      return total;
    endfunction

    function logic [KEY_W-1:0] held_key();
      return keys[$urandom_range(0, total - 1)];
    endfunction

    function int find(logic [KEY_W-1:0] k);
      for (int j = 0; j < total; j++)
        if (keys[j] == k) return j;
      return -1;
    endfunction

    function void log_event(logic [EV_W-1:0] code, logic [KEY_W-1:0] k, logic ins,
                            logic fin);
      table_event_t ev;
      ev.res = code;
      ev.ekey = k;
      ev.inserted = ins;
      ev.held = HELD_W'(total);
      ev.final_beat = fin;
      pending.push_back(ev);
    endfunction

    function void note_command(logic [KIND_W-1:0] kind_v, logic [KEY_W-1:0] k);
      int idx;
      int i;
      int n;
      int top;
      logic [KEY_W-1:0] gone;
      logic ins;
      table_event_t ev;
      case (kind_v)
        KIND_OBSERVE: begin
          idx = find(k);
          if (idx >= 0) begin
            if (obs[idx] != CNT_MAX) obs[idx]++;
            miss[idx] = '0;
            log_event(EV_KNOWN, k, 1'b0, 1'b1);
          end else begin
            ins = 1'b0;
            if (total < DEPTH) begin
              keys[total] = k;
              obs[total] = CNT_W'(1);
              miss[total] = '0;
              seen[total] = 1'b0;
              total++;
              ins = 1'b1;
            end
            log_event(scans > cfg.warmup_scans ? EV_NEW_FLAGGED : EV_NEW_WARMUP, k, ins, 1'b1);
          end
        end
        KIND_MARK: begin
          idx = find(k);
          if (idx >= 0) seen[idx] = 1'b1;
          log_event(EV_DONE, '0, 1'b0, 1'b1);
        end
        KIND_SCAN: begin
          if (scans != CNT_MAX) scans++;
          i = 0;
          n = 0;
          while (i < total) begin
            if (seen[i]) begin
              i++;
            end else begin
              if (miss[i] != CNT_MAX) miss[i]++;
              if (miss[i] > cfg.vanish_misses && obs[i] >= cfg.baseline_observations) begin
                gone = keys[i];
                top = total - 1;
                if (i < top) begin
                  keys[i] = keys[top];
                  obs[i] = obs[top];
                  miss[i] = miss[top];
                  seen[i] = seen[top];
                end
                seen[top] = 1'b0;
                total = top;
                log_event(EV_VANISHED, gone, 1'b0, 1'b0);
                n++;
              end else begin
                i++;
              end
            end
          end
          foreach (seen[j]) seen[j] = 1'b0;
          if (n == 0) begin
            log_event(EV_DONE, '0, 1'b0, 1'b1);
          end else begin
            ev = pending[$];
            void'(pending.pop_back());
            ev.final_beat = 1'b1;
            pending.push_back(ev);
          end
        end
        default: log_event(EV_DONE, '0, 1'b0, 1'b1);
      endcase
    endfunction

    function void note_error(string msg);
      if (errors < 10) $display("mismatch: %s", msg);
      errors++;
    endfunction

    function void check_event(logic [EV_W-1:0] res, logic [KEY_W-1:0] k, logic ins,
                              logic [HELD_W-1:0] held_now, logic fin);
      table_event_t exp_ev;
      if (pending.size() == 0) begin
        note_error($sformatf("unexpected result ev=%0d key=%h ins=%0b held=%0d last=%0b",
                             res, k, ins, held_now, fin));
      end else begin
        exp_ev = pending.pop_front();
        if (exp_ev.res !== res || exp_ev.ekey !== k || exp_ev.inserted !== ins ||
            exp_ev.held !== held_now || exp_ev.final_beat !== fin)
          note_error($sformatf({"expected ev=%0d key=%h ins=%0b held=%0d last=%0b, ",
                                "got ev=%0d key=%h ins=%0b held=%0d last=%0b"},
                               exp_ev.res, exp_ev.ekey, exp_ev.inserted, exp_ev.held,
                               exp_ev.final_beat, res, k, ins, held_now, fin));
      end
    endfunction

    function void close_out();
      if (pending.size() != 0)
        note_error($sformatf("%0d results never arrived", pending.size()));
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst;
  logic                start;
  logic                busy;
  logic [KIND_W-1:0]   kind;
  logic [KEY_W-1:0]    key;
  logic                cfg_valid;
  logic                cfg_ready;
  logic [CIDX_W-1:0]   cfg_index;
  logic [CNT_W-1:0]    cfg_data;
  logic                result_strobe;
  logic [EV_W-1:0]     event_res;
  logic [KEY_W-1:0]    event_key;
  logic                was_inserted;
  logic [HELD_W-1:0]   entries_held;
  logic                last_result;

  address_table_shadow shadow = new();
  bit                  steady = 1'b0;
  int                  quiet = 0;

  address_table_with_aging_unit #(
    .TABLE_DEPTH(DEPTH),
    .KEY_BITS(KEY_W)
  ) dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .kind(kind),
    .key(key),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .result_strobe(result_strobe),
    .event_res(event_res),
    .event_key(event_key),
    .was_inserted(was_inserted),
    .entries_held(entries_held),
    .last_result(last_result)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    if (!rst && result_strobe)
      shadow.check_event(event_res, event_key, was_inserted, entries_held, last_result);
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || result_strobe || (cfg_valid && cfg_ready))
      quiet <= 0;
    else
      quiet <= quiet + 1;
  end

  initial begin
    wait (quiet >= IDLE_LIMIT);
    $display("FAIL address_table_with_aging_unit");
    $finish;
  end

  function automatic logic [KEY_W-1:0] fresh_key();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return r[KEY_W-1:0];
  endfunction

  // start stays high into the next beat when there is no gap
  task automatic send_item(input logic [KIND_W-1:0] k, input logic [KEY_W-1:0] kv);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    kind <= k;
    key <= kv;
    do @(posedge clk); while (busy);
    shadow.note_command(k, kv);
  endtask

  task automatic drain();
    start <= 1'b0;
    do @(posedge clk); while (shadow.outstanding() != 0 || busy);
  endtask

  task automatic set_config(input logic [CNT_W-1:0] warmup, input logic [CNT_W-1:0] vanish,
                            input logic [CNT_W-1:0] baseline, input bit spare);
    logic [CIDX_W-1:0] idx [4];
    logic [CNT_W-1:0]  val [4];
    int beats;
    int b;
    idx[0] = REG_WARMUP;
    val[0] = warmup;
    idx[1] = REG_VANISH;
    val[1] = vanish;
    idx[2] = REG_BASELINE;
    val[2] = baseline;
    idx[3] = REG_SPARE;
    val[3] = CNT_W'($urandom);
    beats = spare ? 4 : 3;
    for (b = 0; b < beats; b++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[b];
      cfg_data <= val[b];
      do @(posedge clk); while (!cfg_ready);
      shadow.write_register(idx[b], val[b]);
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic random_items(input int count, input int fresh_pct, input int scan_pct,
                              input int mark_pct);
    int r;
    logic [KIND_W-1:0] k;
    logic [KEY_W-1:0] kv;
    repeat (count) begin
      if ($urandom_range(0, 9) == 0) steady = !steady;
      r = $urandom_range(0, 99);
      kv = fresh_key();
      if (r < scan_pct) begin
        k = KIND_SCAN;
      end else if (r < scan_pct + 3) begin
        k = KIND_SPARE;
      end else if (r < scan_pct + 3 + mark_pct) begin
        k = KIND_MARK;
        if ($urandom_range(0, 99) < 85 && shadow.held() > 0) kv = shadow.held_key();
      end else begin
        k = KIND_OBSERVE;
        if ($urandom_range(0, 99) >= fresh_pct && shadow.held() > 0) kv = shadow.held_key();
      end
      send_item(k, kv);
    end
  endtask

  initial begin
    rst = 1'b1;
    start = 1'b0;
    kind = KIND_OBSERVE;
    key = '0;
    cfg_valid = 1'b0;
    cfg_index = REG_WARMUP;
    cfg_data = '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // warm-up behaviour with the reset settings
    send_item(KIND_OBSERVE, '0);
    send_item(KIND_OBSERVE, '1);
    send_item(KIND_OBSERVE, '0);
    send_item(KIND_OBSERVE, 48'h8000_0000_0001);
    send_item(KIND_MARK, 48'h0000_0000_1234);
    send_item(KIND_MARK, '1);
    send_item(KIND_SPARE, '1);
    send_item(KIND_SCAN, fresh_key());
    drain();

    // flagging and removal with swap
    set_config(16'd0, 16'd0, 16'd1, 1'b1);
    send_item(KIND_OBSERVE, 48'h5555_5555_5555);
    send_item(KIND_OBSERVE, 48'hAAAA_AAAA_AAAA);
    send_item(KIND_MARK, 48'hAAAA_AAAA_AAAA);
    send_item(KIND_SCAN, '1);
    send_item(KIND_OBSERVE, '0);
    send_item(KIND_SCAN, '0);
    send_item(KIND_SPARE, '0);
    drain();

    set_config(16'd2, 16'd1, 16'd2, 1'b0);
    random_items(40, 40, 15, 25);
    drain();

    // fill past capacity; nothing ever vanishes or gets flagged
    set_config(16'hFFFF, 16'hFFFE, 16'hFFFF, 1'b0);
    random_items(80, 100, 2, 8);
    drain();

    // mass removal from a full table
    set_config(16'd0, 16'd0, 16'd1, 1'b1);
    random_items(40, 30, 20, 25);
    drain();

    set_config(CNT_W'($urandom_range(0, 8)), CNT_W'($urandom_range(0, 3)),
               CNT_W'($urandom_range(1, 4)), 1'b0);
    random_items(40, 35, 15, 25);
    drain();

    repeat (SETTLE_CYCLES) @(posedge clk);
    shadow.close_out();
    if (shadow.errors == 0)
      $display("PASS address_table_with_aging_unit");
    else
      $display("FAIL address_table_with_aging_unit");
    $finish;
  end

endmodule
